FILE: rtl/ps2sc_pkg.sv
// Package with shared types, scancode constants and the keymap lookup of the translator.
package ps2sc_pkg;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3a;
  localparam logic [7:0] SC_NUM_MAKE     = 8'h45;
  localparam logic [7:0] SC_SCROLL_MAKE  = 8'h46;

  localparam logic [6:0] CASE_OFFSET = 7'h20;
  localparam logic [6:0] ASCII_UC_A  = 7'h41;
  localparam logic [6:0] ASCII_UC_Z  = 7'h5a;

  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  typedef struct packed {
    logic [1:0] shift;
    logic [2:0] leds;
  } kbd_state_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       led_update;
    logic [2:0] led_state;
  } kbd_result_t;

  // Keymap for make codes; shifted selects the second column.
  function automatic logic [6:0] keymap(input logic [6:0] code, input logic shifted);
    logic [6:0] ch;
    unique case (code)
      7'h02: ch = shifted ? 7'h21 : 7'h31;
      7'h03: ch = shifted ? 7'h40 : 7'h32;
      7'h04: ch = shifted ? 7'h23 : 7'h33;
      7'h05: ch = shifted ? 7'h24 : 7'h34;
      7'h06: ch = shifted ? 7'h25 : 7'h35;
      7'h07: ch = shifted ? 7'h5e : 7'h36;
      7'h08: ch = shifted ? 7'h26 : 7'h37;
      7'h09: ch = shifted ? 7'h2a : 7'h38;
      7'h0a: ch = shifted ? 7'h28 : 7'h39;
      7'h0b: ch = shifted ? 7'h29 : 7'h30;
      7'h0c: ch = shifted ? 7'h5f : 7'h2d;
      7'h0d: ch = shifted ? 7'h2b : 7'h3d;
      7'h0e: ch = 7'h08;
      7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;
      7'h12: ch = 7'h45;
      7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;
      7'h16: ch = 7'h55;
      7'h17: ch = 7'h49;
      7'h18: ch = 7'h4f;
      7'h19: ch = 7'h50;
      7'h1a: ch = shifted ? 7'h7b : 7'h5b;
      7'h1b: ch = shifted ? 7'h7d : 7'h5d;
      7'h1c: ch = 7'h0a;
      7'h1e: ch = 7'h41;
      7'h1f: ch = 7'h53;
      7'h20: ch = 7'h44;
      7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;
      7'h23: ch = 7'h48;
      7'h24: ch = 7'h4a;
      7'h25: ch = 7'h4b;
      7'h26: ch = 7'h4c;
      7'h27: ch = shifted ? 7'h3a : 7'h3b;
      7'h28: ch = shifted ? 7'h22 : 7'h27;
      7'h29: ch = shifted ? 7'h7e : 7'h60;
      7'h2b: ch = shifted ? 7'h7c : 7'h5c;
      7'h2c: ch = 7'h5a;
      7'h2d: ch = 7'h58;
      7'h2e: ch = 7'h43;
      7'h2f: ch = 7'h56;
      7'h30: ch = 7'h42;
      7'h31: ch = 7'h4e;
      7'h32: ch = 7'h4d;
      7'h33: ch = shifted ? 7'h3c : 7'h2c;
      7'h34: ch = shifted ? 7'h3e : 7'h2e;
      7'h35: ch = shifted ? 7'h3f : 7'h2f;
      7'h37: ch = 7'h2a;
      7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;
      7'h48: ch = 7'h38;
      7'h49: ch = 7'h39;
      7'h4a: ch = 7'h2d;
      7'h4b: ch = 7'h34;
      7'h4c: ch = 7'h35;
      7'h4d: ch = 7'h36;
      7'h4e: ch = 7'h2b;
      7'h4f: ch = 7'h31;
      7'h50: ch = 7'h32;
      7'h51: ch = 7'h33;
      7'h52: ch = 7'h30;
      7'h53: ch = 7'h2e;
      7'h73: ch = shifted ? 7'h5f : 7'h5c;
      7'h7d: ch = shifted ? 7'h7c : 7'h5c;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/ps2sc_xlate.sv
// Translation of one scancode against the current shift and lock state.
module ps2sc_xlate import ps2sc_pkg::*; (
  input  logic [7:0]  scancode,
  input  kbd_state_t  state_cur,
  output kbd_state_t  state_nxt,
  output kbd_result_t result
);

  logic       shifted;
  logic       caps;
  logic [6:0] raw_ch;
  logic [6:0] ch;
  logic       upd;

  assign shifted = (state_cur.shift != 2'b00);
  assign caps    = (state_cur.leds & LED_CAPS) != 3'b000;

  always_comb begin
    raw_ch = scancode[7] ? 7'h00 : keymap(scancode[6:0], shifted);
    // Letters come out of the table upper case; lower them unless exactly
    // one of shift and caps lock is in effect.
    if (raw_ch >= ASCII_UC_A && raw_ch <= ASCII_UC_Z && shifted == caps) begin
      ch = raw_ch + CASE_OFFSET;
    end else begin
      ch = raw_ch;
    end
  end

  always_comb begin
    state_nxt = state_cur;
    upd       = 1'b0;
    unique case (scancode)
      SC_LSHIFT_MAKE:  state_nxt.shift = state_cur.shift | 2'b01;
      SC_RSHIFT_MAKE:  state_nxt.shift = state_cur.shift | 2'b10;
      SC_LSHIFT_BREAK: state_nxt.shift = state_cur.shift & 2'b10;
      SC_RSHIFT_BREAK: state_nxt.shift = state_cur.shift & 2'b01;
      SC_CAPS_MAKE: begin
        state_nxt.leds = state_cur.leds ^ LED_CAPS;
        upd            = 1'b1;
      end
      SC_NUM_MAKE: begin
        state_nxt.leds = state_cur.leds ^ LED_NUM;
        upd            = 1'b1;
      end
      SC_SCROLL_MAKE: begin
        state_nxt.leds = state_cur.leds ^ LED_SCROLL;
        upd            = 1'b1;
      end
      default: ;
    endcase
  end

  assign result.char_valid = (ch != 7'h00);
  assign result.char_code  = ch;
  assign result.led_update = upd;
  assign result.led_state  = state_nxt.leds;

endmodule

FILE: rtl/ps2_scancode_to_ascii.sv
// Set-1 scancode to ASCII translator: top level with input and result registers.
// One scancode beat is taken per cycle while the output is not stalled: the
// byte lands in an input register, the keymap lookup and shift/lock update run
// combinationally from there, and the result sits in an output register until taken.
// Every input beat yields exactly one result beat carrying the character (if any),
// an LED update flag and the lock LED state. When the flag is set, the host should
// send 0xED to the keyboard followed by led_state. Shift and lock state reset to zero.
module ps2_scancode_to_ascii import ps2sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_char_valid,
  output logic [6:0] out_char_code,
  output logic       out_led_update,
  output logic [2:0] out_led_state
);

  logic        in_vld_r;
  logic [7:0]  code_r;
  logic        out_vld_r;
  kbd_result_t res_r;
  kbd_state_t  state_r;
  kbd_state_t  state_nxt;
  kbd_result_t res_nxt;
  logic        fire;
  logic        in_take;

  // The translate step fires when the output register is free or draining.
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  ps2sc_xlate u_xlate (
    .scancode  (code_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      code_r <= in_scancode;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_char_valid = res_r.char_valid;
  assign out_char_code  = res_r.char_code;
  assign out_led_update = res_r.led_update;
  assign out_led_state  = res_r.led_state;

endmodule

FILE: rtl/ps2sc_checker.sv
// Port-level checker for the scancode translator and its bind to the top level.
module ps2sc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_char_valid,
  input logic [6:0] out_char_code,
  input logic       out_led_update,
  input logic [2:0] out_led_state
);

  // The character flag must agree with the code it qualifies.
  a_char_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_valid == (out_char_code != 7'h00)))
    else $error("char_valid disagrees with char_code");

  // Lock keys have no keymap entry, so an LED update never carries a character.
  a_led_nochar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_led_update) |-> !out_char_valid)
    else $error("LED update beat carries a character");

  // Without an LED update the lock state cannot change between results.
  a_led_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 (out_valid && !out_led_update)
      |-> out_led_state == $past(out_led_state))
    else $error("lock state changed without an LED update");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_char_code)
      && $stable(out_led_state)))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ps2_scancode_to_ascii ps2sc_checker u_ps2sc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char_valid (out_char_valid),
  .out_char_code  (out_char_code),
  .out_led_update (out_led_update),
  .out_led_state  (out_led_state)
);

FILE: tb/tb_ps2_scancode_to_ascii.sv
// Self-checking testbench for the set-1 scancode to ASCII translator with a scoreboard.
`timescale 1ns / 1ps

module tb_ps2_scancode_to_ascii;
  import ps2sc_pkg::*;

  // Predicts one result per scancode beat and checks results in order.
  class keymap_scoreboard;
    logic [1:0] shift_held;
    logic [2:0] lock_bits;
    kbd_result_t expected_q[$];
    int errors;

    bit [6:0] plain_map [128] = '{
      'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
      'h37, 'h38, 'h39, 'h30, 'h2d, 'h3d, 'h08, 'h00,
      'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
      'h4f, 'h50, 'h5b, 'h5d, 'h0a, 'h00, 'h41, 'h53,
      'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h3b,
      'h27, 'h60, 'h00, 'h5c, 'h5a, 'h58, 'h43, 'h56,
      'h42, 'h4e, 'h4d, 'h2c, 'h2e, 'h2f, 'h00, 'h2a,
      'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37,
      'h38, 'h39, 'h2d, 'h34, 'h35, 'h36, 'h2b, 'h31,
      'h32, 'h33, 'h30, 'h2e, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h5c, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h5c, 'h00, 'h00
    };

    bit [6:0] shifted_map [128] = '{
      'h00, 'h00, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5e,
      'h26, 'h2a, 'h28, 'h29, 'h5f, 'h2b, 'h08, 'h00,
      'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
      'h4f, 'h50, 'h7b, 'h7d, 'h0a, 'h00, 'h41, 'h53,
      'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h3a,
      'h22, 'h7e, 'h00, 'h7c, 'h5a, 'h58, 'h43, 'h56,
      'h42, 'h4e, 'h4d, 'h3c, 'h3e, 'h3f, 'h00, 'h2a,
      'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37,
      'h38, 'h39, 'h2d, 'h34, 'h35, 'h36, 'h2b, 'h31,
      'h32, 'h33, 'h30, 'h2e, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h5f, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h7c, 'h00, 'h00
    };

    function new();
      shift_held = '0;
      lock_bits  = '0;
      errors     = 0;
    endfunction

    function void note_scancode(logic [7:0] code);
      kbd_result_t r;
      logic [6:0] ch;
      ch = '0;
      r.led_update = 1'b0;
      if (!code[7])
        ch = (shift_held == 2'b00) ? plain_map[code[6:0]] : shifted_map[code[6:0]];
      // Letters come out upper case only when shift and caps lock disagree.
      if (ch >= ASCII_UC_A && ch <= ASCII_UC_Z && ((shift_held != 2'b00) == lock_bits[2]))
        ch = ch + CASE_OFFSET;
      case (code)
        SC_LSHIFT_MAKE:  shift_held[0] = 1'b1;
        SC_RSHIFT_MAKE:  shift_held[1] = 1'b1;
        SC_LSHIFT_BREAK: shift_held[0] = 1'b0;
        SC_RSHIFT_BREAK: shift_held[1] = 1'b0;
        SC_CAPS_MAKE: begin
          lock_bits = lock_bits ^ LED_CAPS;
          r.led_update = 1'b1;
        end
        SC_NUM_MAKE: begin
          lock_bits = lock_bits ^ LED_NUM;
          r.led_update = 1'b1;
        end
        SC_SCROLL_MAKE: begin
          lock_bits = lock_bits ^ LED_SCROLL;
          r.led_update = 1'b1;
        end
        default: ;
      endcase
      r.char_valid = (ch != '0);
      r.char_code  = ch;
      r.led_state  = lock_bits;
      expected_q.push_back(r);
    endfunction

    function void check_result(kbd_result_t got);
      kbd_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.char_valid !== want.char_valid) begin
        $error("char_valid: expected %0d, got %0d", want.char_valid, got.char_valid);
        errors++;
      end
      if (got.char_code !== want.char_code) begin
        $error("char_code: expected %h, got %h", want.char_code, got.char_code);
        errors++;
      end
      if (got.led_update !== want.led_update) begin
        $error("led_update: expected %0d, got %0d", want.led_update, got.led_update);
        errors++;
      end
      if (got.led_state !== want.led_state) begin
        $error("led_state: expected %b, got %b", want.led_state, got.led_state);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_scancode = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_char_valid;
  logic [6:0] out_char_code;
  logic       out_led_update;
  logic [2:0] out_led_state;

  keymap_scoreboard sb;
  logic in_taken = 1'b0;
  bit   idle_on = 1'b1;
  int   sent_count = 0;

  ps2_scancode_to_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scancode    (in_scancode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_valid (out_char_valid),
    .out_char_code  (out_char_code),
    .out_led_update (out_led_update),
    .out_led_state  (out_led_state)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 10);
  end

  // Sampling on the falling edge sees the values that the next rising edge will act on.
  // The result is checked before the new input is noted so an early result is not masked.
  always @(negedge clk) begin
    kbd_result_t got;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got.char_valid = out_char_valid;
      got.char_code  = out_char_code;
      got.led_update = out_led_update;
      got.led_state  = out_led_state;
      sb.check_result(got);
    end
    if (in_taken)
      sb.note_scancode(in_scancode);
  end

  task automatic send_code(input logic [7:0] code);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_scancode <= code;
    @(posedge clk);
    while (!in_taken) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_typing(input int count);
    for (int i = 0; i < count; i++)
      send_code(8'($urandom_range(0, 127)));
  endtask

  initial begin
    int kind;
    bit drained_once;
    logic [7:0] code;
    logic [7:0] lock_codes [3];
    sb = new();
    drained_once = 1'b0;
    lock_codes = '{SC_CAPS_MAKE, SC_NUM_MAKE, SC_SCROLL_MAKE};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: table edges, shifts, locks, break and acknowledge bytes.
    send_code(8'h00);
    send_code(8'h7f);
    send_code(8'hff);
    send_code(8'h80);
    send_code(8'h1e);
    send_code(8'h02);
    send_code(SC_LSHIFT_MAKE);
    send_code(8'h1e);
    send_code(8'h02);
    send_code(8'h35);
    send_code(8'h73);
    send_code(8'h7d);
    send_code(SC_LSHIFT_BREAK);
    send_code(SC_CAPS_MAKE);
    send_code(8'h1e);
    send_code(SC_RSHIFT_MAKE);
    send_code(8'h1e);
    send_code(SC_LSHIFT_BREAK);
    send_code(8'h2c);
    send_code(SC_RSHIFT_BREAK);
    send_code(SC_CAPS_MAKE | 8'h80);
    send_code(SC_NUM_MAKE);
    send_code(SC_SCROLL_MAKE);
    send_code(8'hfa);
    send_code(8'hfe);
    send_code(SC_CAPS_MAKE);
    wait_drained();

    while (sent_count < 1320) begin
      idle_on = !(sent_count >= 500 && sent_count < 850);
      if (!drained_once && sent_count >= 700) begin
        wait_drained();
        drained_once = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 40) begin
        code = 8'($urandom_range(0, 127));
        send_code(code);
        if ($urandom_range(1))
          send_code(code | 8'h80);
      end else if (kind < 55) begin
        if ($urandom_range(1)) begin
          send_code(SC_LSHIFT_MAKE);
          send_typing($urandom_range(1, 5));
          send_code(SC_LSHIFT_BREAK);
        end else begin
          send_code(SC_RSHIFT_MAKE);
          send_typing($urandom_range(1, 5));
          send_code(SC_RSHIFT_BREAK);
        end
      end else if (kind < 65) begin
        code = lock_codes[$urandom_range(0, 2)];
        send_code(code);
        send_code(code | 8'h80);
      end else if (kind < 75) begin
        // Overlapping shifts: releasing one must leave the other in effect.
        send_code(SC_LSHIFT_MAKE);
        send_code(SC_RSHIFT_MAKE);
        send_typing($urandom_range(1, 3));
        send_code($urandom_range(1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
        send_typing($urandom_range(1, 3));
        send_code(SC_LSHIFT_BREAK);
        send_code(SC_RSHIFT_BREAK);
      end else begin
        send_code(8'($urandom_range(0, 255)));
      end
    end

    idle_on = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
